// ----- rtl/depth_autorange_jet_colour_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the depth auto-range jet colouring core
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef DEPTH_AUTORANGE_JET_COLOUR_CORE_MACROS_SVH
`define DEPTH_AUTORANGE_JET_COLOUR_CORE_MACROS_SVH

// Check that cond implies prop in the same cycle
`define DAJC_ASSERT_IMPL(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// Check that cond implies prop in the next cycle
`define DAJC_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- rtl/dajc_pkg.sv -----
// ----------------------------------------------------------------------------
// Depth auto-range jet colouring package
// Sequencer states, channel codes and default parameters.
// ----------------------------------------------------------------------------
`default_nettype none

package dajc_pkg;

  // Default saturation level of the valid-pixel count
  localparam int unsigned MAX_PIXELS_DEF = 32768;

  // Width of depth samples and statistics
  localparam int unsigned DEPTH_W = 16;

  // Operation codes of a request
  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_COLOUR  = 1'b1;

  // Channel centers, k in clamp(1.5 - |4u - k|, 0, 1)
  localparam logic [1:0] CHAN_RED   = 2'd3;
  localparam logic [1:0] CHAN_GREEN = 2'd2;
  localparam logic [1:0] CHAN_BLUE  = 2'd1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_CHAN,
    ST_WRITE
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/depth_autorange_jet_colour_core.sv -----
// ----------------------------------------------------------------------------
// Depth auto-range jet colouring core
// Gathers per-frame depth statistics and maps depths onto a jet palette.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one request: op_i, depth_value_i
//   and first_i. A measure request folds a nonzero depth into the running
//   minimum, maximum and saturating count; first_i restarts them. A colour
//   request normalizes the depth against the gathered range and returns RGB.
//   Output channel (out_valid_o / out_stall_i) returns one result per request
//   with the colour and the current range and count.
//   Sequence: a measure request passes from acceptance through the preparation
//   and write states to the output register; a colour request passes through
//   preparation, the restoring divider (one quotient bit a cycle), the shared
//   channel unit (red, green, then blue) and the write state. Black colour
//   requests go from preparation straight to write, and a depth at or above the
//   maximum skips the divider. in_stall_o is high until the result is written,
//   so a new request is taken in the cycle after the write.
//   A finished request waits in the write state while out_stall_i holds a
//   result in the output register. Reset clears the statistics (minimum
//   65535, maximum 0, count 0) and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

`include "depth_autorange_jet_colour_core_macros.svh"

module depth_autorange_jet_colour_core
  import dajc_pkg::*;
#(
  parameter int unsigned MaxPixels = MAX_PIXELS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               op_i,
  input  wire logic [DEPTH_W-1:0] depth_value_i,
  input  wire logic               first_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [7:0]              red_o,
  output logic [7:0]              green_o,
  output logic [7:0]              blue_o,
  output logic [DEPTH_W-1:0]      range_low_o,
  output logic [DEPTH_W-1:0]      range_high_o,
  output logic [DEPTH_W-1:0]      valid_pixels_o
);

  localparam int unsigned CapInt = (MaxPixels < 65535) ? MaxPixels : 65535;
  localparam logic [DEPTH_W-1:0] CountCap = DEPTH_W'(CapInt);

  // Map u in unsigned Q1.16 onto one channel byte
  function automatic logic [7:0] chan_byte(input logic [16:0] u, input logic [1:0] k);
    logic [18:0] four_u;
    logic [18:0] centre;
    logic [18:0] delta;
    logic [16:0] v;
    logic [24:0] prod;
    four_u = {u, 2'b00};
    centre = {1'b0, k, 16'h0000};
    delta  = (four_u >= centre) ? (four_u - centre) : (centre - four_u);
    if (delta >= 19'd98304) begin
      v = 17'd0;
    end else begin
      v = 17'(19'd98304 - delta);
    end
    if (v > 17'd65536) begin
      v = 17'd65536;
    end
    prod = ({8'd0, v} << 8) - {8'd0, v} + 25'd32768;
    return prod[23:16];
  endfunction

  state_e state_q, state_d;

  logic               accept;
  logic               out_free;
  logic               op_q;
  logic               first_q;
  logic [DEPTH_W-1:0] depth_q;
  logic [DEPTH_W-1:0] min_q;
  logic [DEPTH_W-1:0] max_q;
  logic [DEPTH_W-1:0] count_q;
  logic [DEPTH_W-1:0] span_q;
  logic [DEPTH_W-1:0] rem_q;
  logic [DEPTH_W-1:0] quo_q;
  logic [16:0]        u_q;
  logic [3:0]         div_cnt_q;
  logic [1:0]         chan_q;
  logic [7:0]         red_q;
  logic [7:0]         green_q;
  logic [7:0]         blue_q;

  // Statistics after a measure request
  logic [DEPTH_W-1:0] base_min;
  logic [DEPTH_W-1:0] base_max;
  logic [DEPTH_W-1:0] base_count;
  logic [DEPTH_W-1:0] meas_min;
  logic [DEPTH_W-1:0] meas_max;
  logic [DEPTH_W-1:0] meas_count;

  // Colour preparation
  logic               colour_ok;
  logic               full_scale;
  logic [DEPTH_W-1:0] span_c;
  logic [DEPTH_W-1:0] dist_c;

  // Divider step
  logic [DEPTH_W:0]   rem_shift;
  logic               rem_ge;
  logic [DEPTH_W-1:0] rem_next;
  logic [DEPTH_W-1:0] quo_next;
  logic [7:0]         chan_val;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_o || !out_stall_i;

  // Fold one depth into the statistics
  always_comb begin
    base_min   = first_q ? {DEPTH_W{1'b1}} : min_q;
    base_max   = first_q ? '0 : max_q;
    base_count = first_q ? '0 : count_q;
    meas_min   = base_min;
    meas_max   = base_max;
    meas_count = base_count;
    if (depth_q != '0) begin
      if (depth_q < base_min) begin
        meas_min = depth_q;
      end
      if (depth_q > base_max) begin
        meas_max = depth_q;
      end
      if (base_count < CountCap) begin
        meas_count = base_count + DEPTH_W'(1);
      end
    end
  end

  // Clamp the depth into the range
  always_comb begin
    colour_ok = (depth_q != '0) && (count_q != '0) && (max_q > min_q);
    span_c    = max_q - min_q;
    if (depth_q <= min_q) begin
      dist_c = '0;
    end else if (depth_q >= max_q) begin
      dist_c = span_c;
    end else begin
      dist_c = depth_q - min_q;
    end
    full_scale = (dist_c == span_c);
  end

  // Restoring divider step and channel unit
  assign rem_shift = {rem_q, 1'b0};
  assign rem_ge    = (rem_shift >= {1'b0, span_q});
  assign rem_next  = rem_ge ? DEPTH_W'(rem_shift - {1'b0, span_q}) : rem_shift[DEPTH_W-1:0];
  assign quo_next  = {quo_q[DEPTH_W-2:0], rem_ge};
  assign chan_val  = chan_byte(u_q, chan_q);

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and handshake
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (accept) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        priority if (op_q == OP_MEASURE || !colour_ok) begin
          state_d = ST_WRITE;
        end else if (full_scale) begin
          state_d = ST_CHAN;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_cnt_q == 4'hF) begin
          state_d = ST_CHAN;
        end
      end
      ST_CHAN: begin
        if (chan_q == CHAN_BLUE) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_i;
      depth_q <= depth_value_i;
      first_q <= first_i;
    end
  end

  // Update statistics on measure
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= {DEPTH_W{1'b1}};
      max_q   <= '0;
      count_q <= '0;
    end else if (state_q == ST_PREP && op_q == OP_MEASURE) begin
      min_q   <= meas_min;
      max_q   <= meas_max;
      count_q <= meas_count;
    end
  end

  // Run the divider and the channel unit
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_PREP: begin
        red_q     <= '0;
        green_q   <= '0;
        blue_q    <= '0;
        span_q    <= span_c;
        rem_q     <= dist_c;
        quo_q     <= '0;
        div_cnt_q <= '0;
        chan_q    <= CHAN_RED;
        u_q       <= '0;
      end
      ST_DIV: begin
        rem_q     <= rem_next;
        quo_q     <= quo_next;
        div_cnt_q <= div_cnt_q + 4'd1;
        u_q       <= 17'h10000 - {1'b0, quo_next};
      end
      ST_CHAN: begin
        unique case (chan_q)
          CHAN_RED:   red_q   <= chan_val;
          CHAN_GREEN: green_q <= chan_val;
          default:    blue_q  <= chan_val;
        endcase
        chan_q <= chan_q - 2'd1;
      end
      default: begin
      end
    endcase
  end

  // Output register valid: set on write, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (state_q == ST_WRITE && out_free) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_WRITE && out_free) begin
      red_o          <= red_q;
      green_o        <= green_q;
      blue_o         <= blue_q;
      range_low_o    <= (count_q != '0) ? min_q : '0;
      range_high_o   <= (count_q != '0) ? max_q : '0;
      valid_pixels_o <= count_q;
    end
  end

  // Checks on the statistics, the divider and the input handshake
  `DAJC_ASSERT_IMPL(a_count_cap, 1'b1, count_q <= CountCap, "valid count above cap")
  `DAJC_ASSERT_IMPL(a_range_order, count_q != '0, min_q <= max_q, "minimum above maximum")
  `DAJC_ASSERT_IMPL(a_div_rem, state_q == ST_DIV, rem_q < span_q, "divider remainder not below span")
  `DAJC_ASSERT_NEXT(a_busy_stall, state_q != ST_IDLE, in_stall_o || state_q == ST_IDLE,
                    "request accepted while busy")

endmodule

`default_nettype wire

// ----- dv/depth_autorange_jet_colour_core_tb.sv -----
// ----------------------------------------------------------------------------
// Testbench for the depth auto-range jet colouring core
// Drives measure and colour requests through the valid/stall channels, keeps
// a bit-exact fixed-point copy of the frame statistics and the jet palette,
// and checks every returned result field by field in request order.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_autorange_jet_colour_core_tb;
  import dajc_pkg::*;

  localparam int unsigned CountCap   = (MAX_PIXELS_DEF < 65535) ? MAX_PIXELS_DEF : 65535;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned DrainTail  = 40;
  localparam int unsigned RandomReqs = 1500;

  // One returned pixel: colour plus the statistics after the request
  typedef struct packed {
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [DEPTH_W-1:0] range_low;
    logic [DEPTH_W-1:0] range_high;
    logic [DEPTH_W-1:0] valid_pixels;
  } pixel_result_t;

  // Frame statistics, jet palette and the queue of pixels still to come
  class jet_stats_board;
    logic [DEPTH_W-1:0] depth_min;
    logic [DEPTH_W-1:0] depth_max;
    logic [DEPTH_W-1:0] depth_count;
    pixel_result_t      pending_pixels[$];
    int unsigned        mismatches;

    function new();
      restart_frame();
      mismatches = 0;
    endfunction

    function void restart_frame();
      depth_min   = 16'hFFFF;
      depth_max   = 16'h0000;
      depth_count = 16'h0000;
    endfunction

    // One palette channel: clamp(1.5 - |4u - k|, 0, 1) * 255, round half up
    function logic [7:0] jet_channel(longint u, logic [1:0] k);
      longint centre;
      longint delta;
      longint level;
      centre = k;
      centre = centre * 65536;
      delta  = 4 * u - centre;
      if (delta < 0) delta = -delta;
      level = (delta >= 98304) ? 0 : 98304 - delta;
      if (level > 65536) level = 65536;
      return 8'((level * 255 + 32768) >>> 16);
    endfunction

    // Fold an accepted request into the statistics and queue its pixel
    function void fold_request(logic op, logic [DEPTH_W-1:0] depth, logic first);
      pixel_result_t pix;
      longint span;
      longint offs;
      longint frac;
      longint flip;
      pix = '0;
      if (op == OP_MEASURE) begin
        if (first) restart_frame();
        if (depth != 0) begin
          if (depth < depth_min) depth_min = depth;
          if (depth > depth_max) depth_max = depth;
          if (depth_count < CountCap) depth_count = depth_count + 1'b1;
        end
      end else if (depth != 0 && depth_count != 0 && depth_max > depth_min) begin
        span = depth_max - depth_min;
        if (depth <= depth_min) offs = 0;
        else if (depth >= depth_max) offs = span;
        else offs = depth - depth_min;
        frac = (offs << 16) / span;
        if (frac > 65536) frac = 65536;
        flip = 65536 - frac;
        pix.red   = jet_channel(flip, CHAN_RED);
        pix.green = jet_channel(flip, CHAN_GREEN);
        pix.blue  = jet_channel(flip, CHAN_BLUE);
      end
      pix.range_low    = (depth_count != 0) ? depth_min : '0;
      pix.range_high   = (depth_count != 0) ? depth_max : '0;
      pix.valid_pixels = depth_count;
      pending_pixels.push_back(pix);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    // Check a returned pixel against the oldest one queued
    function void match_result(pixel_result_t got);
      pixel_result_t want;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = pending_pixels.pop_front();
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
      compare_field("range_low", want.range_low, got.range_low);
      compare_field("range_high", want.range_high, got.range_high);
      compare_field("valid_pixels", want.valid_pixels, got.valid_pixels);
    endfunction

    function int unsigned outstanding();
      return pending_pixels.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               op_i = OP_MEASURE;
  logic [DEPTH_W-1:0] depth_value_i = '0;
  logic               first_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [7:0]         red_o;
  logic [7:0]         green_o;
  logic [7:0]         blue_o;
  logic [DEPTH_W-1:0] range_low_o;
  logic [DEPTH_W-1:0] range_high_o;
  logic [DEPTH_W-1:0] valid_pixels_o;

  jet_stats_board board;
  bit             calm = 1'b0;
  int unsigned    requests_sent = 0;
  int unsigned    quiet_cycles = 0;

  depth_autorange_jet_colour_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .depth_value_i  (depth_value_i),
    .first_i        (first_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .range_low_o    (range_low_o),
    .range_high_o   (range_high_o),
    .valid_pixels_o (valid_pixels_o)
  );

  always #6 clk_i = ~clk_i;

  // Stall the result channel now and then, never while calm
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 10);
  end

  // Observe both handshakes; check results before folding the new request
  always @(posedge clk_i) begin
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        board.match_result({red_o, green_o, blue_o, range_low_o, range_high_o,
                            valid_pixels_o});
        moved = 1'b1;
      end
      if (in_valid_i && !in_stall_o) begin
        board.fold_request(op_i, depth_value_i, first_i);
        moved = 1'b1;
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Present one request, with an occasional gap first, and hold until taken
  task automatic send_request(input logic op, input logic [DEPTH_W-1:0] depth,
                              input logic first);
    int unsigned gap;
    if (!calm && $urandom_range(0, 99) < 10) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    depth_value_i <= depth;
    first_i       <= first;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    requests_sent++;
  endtask

  // Hold off until every queued pixel has returned, then let the core settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (DrainTail) @(posedge clk_i);
  endtask

  function automatic logic [DEPTH_W-1:0] depth_near(int unsigned base, int unsigned span);
    int unsigned pick;
    pick = base + $urandom_range(0, span);
    return (pick > 65535) ? 16'hFFFF : pick[DEPTH_W-1:0];
  endfunction

  // Edges of the fields and every named corner of the behavior
  task automatic run_directed();
    // empty after reset, restart with zero depth, first flag on colour
    send_request(OP_COLOUR, 16'd500, 1'b0);
    send_request(OP_MEASURE, 16'd0, 1'b1);
    send_request(OP_COLOUR, 16'd500, 1'b1);
    // flat range
    send_request(OP_MEASURE, 16'd1000, 1'b1);
    send_request(OP_COLOUR, 16'd1000, 1'b0);
    // widest range, zero depth on both operations
    send_request(OP_MEASURE, 16'd1, 1'b0);
    send_request(OP_MEASURE, 16'hFFFF, 1'b0);
    send_request(OP_MEASURE, 16'd0, 1'b0);
    send_request(OP_COLOUR, 16'd0, 1'b0);
    send_request(OP_COLOUR, 16'd1, 1'b0);
    send_request(OP_COLOUR, 16'hFFFF, 1'b0);
    send_request(OP_COLOUR, 16'h8000, 1'b0);
    send_request(OP_COLOUR, 16'h4000, 1'b0);
    send_request(OP_COLOUR, 16'hC000, 1'b0);
    send_request(OP_COLOUR, 16'h2000, 1'b0);
    // depths below and above a narrow range
    send_request(OP_MEASURE, 16'd1000, 1'b1);
    send_request(OP_MEASURE, 16'd2000, 1'b0);
    send_request(OP_COLOUR, 16'd500, 1'b0);
    send_request(OP_COLOUR, 16'd3000, 1'b0);
    send_request(OP_COLOUR, 16'd1500, 1'b1);
    send_request(OP_COLOUR, 16'd1250, 1'b0);
    send_request(OP_COLOUR, 16'd1751, 1'b0);
    // one-step range at the top of the scale
    send_request(OP_MEASURE, 16'hFFFF, 1'b1);
    send_request(OP_MEASURE, 16'hFFFE, 1'b0);
    send_request(OP_COLOUR, 16'hFFFF, 1'b0);
    send_request(OP_COLOUR, 16'hFFFE, 1'b0);
  endtask

  // A well-formed frame: measure pass over a random range, then colour pass
  task automatic run_frame();
    int unsigned n_measure;
    int unsigned n_colour;
    int unsigned base;
    int unsigned span;
    int unsigned roll;
    logic [DEPTH_W-1:0] depth;
    n_measure = $urandom_range(1, 24);
    n_colour  = $urandom_range(1, 24);
    base      = $urandom_range(1, 65535);
    case ($urandom_range(0, 3))
      0: span = $urandom_range(0, 3);
      1: span = $urandom_range(0, 255);
      2: span = $urandom_range(0, 4095);
      default: span = $urandom_range(0, 65535);
    endcase
    for (int unsigned i = 0; i < n_measure; i++) begin
      roll  = $urandom_range(0, 99);
      depth = (roll < 10) ? '0 : depth_near(base, span);
      // mostly restart at the head of the frame, sometimes carry over
      send_request(OP_MEASURE, depth, (i == 0) ? ($urandom_range(0, 9) != 0) : 1'b0);
    end
    for (int unsigned i = 0; i < n_colour; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) depth = '0;
      else if (roll < 20) depth = 16'($urandom_range(0, 65535));
      else depth = depth_near(base, span);
      send_request(OP_COLOUR, depth, 1'($urandom_range(0, 1)));
    end
  endtask

  // Unstructured requests over the whole field ranges
  task automatic run_noise();
    int unsigned n_noise;
    n_noise = $urandom_range(1, 8);
    repeat (n_noise)
      send_request(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                   1'($urandom_range(0, 1)));
  endtask

  task automatic run_random(input int unsigned goal);
    while (requests_sent < goal) begin
      // keep a long stretch free of gaps and stalls
      calm = (requests_sent >= 600 && requests_sent < 900);
      if ($urandom_range(0, 9) < 8) run_frame();
      else run_noise();
    end
    calm = 1'b0;
  endtask

  initial begin
    board = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    drain_results();
    run_random(requests_sent + RandomReqs / 2);
    drain_results();
    run_random(requests_sent + RandomReqs / 2);
    drain_results();
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/dajc_pkg.sv
rtl/depth_autorange_jet_colour_core.sv
dv/depth_autorange_jet_colour_core_tb.sv
